FILE: rtl/float_to_engineering_text_top_macros.svh
// ----------------------------------------------------------------------------
// float_to_engineering_text_top_macros
// Assertion macros shared by the float to engineering text block.
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_ENGINEERING_TEXT_TOP_MACROS_SVH
`define FLOAT_TO_ENGINEERING_TEXT_TOP_MACROS_SVH

// same-cycle implication
`define FTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Types, constants and helpers of the float to engineering text block.
// ----------------------------------------------------------------------------
package fte_pkg;

	localparam int WIDE_W      = 160;
	localparam int MANT_DIGITS = 4;
	localparam int DIG_IDX_W   = $clog2(MANT_DIGITS);

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_DOT   = 8'h2E;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	typedef logic [WIDE_W-1:0] wide_t;

	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_ZERO,
		KIND_INVALID
	} kind_t;

	typedef struct packed {
		logic              neg;
		kind_t             kind;
		logic [23:0]       mant;
		logic signed [8:0] bexp2;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_NORM_UP,
		ST_NORM_DN,
		ST_DIGIT,
		ST_DONE
	} state_t;

	function automatic wide_t mul10(input wide_t x);
		mul10 = (x << 3) + (x << 1);
	endfunction

endpackage

FILE: rtl/fte_front.sv
// ----------------------------------------------------------------------------
// fte_front
// Decodes the single-precision pattern into sign, class, mantissa and
// binary exponent.
// ----------------------------------------------------------------------------
module fte_front import fte_pkg::*; (
	input  logic [31:0] value_bits,
	output item_t       item
);

	logic [7:0]  bexp;
	logic [22:0] frac;

	assign bexp = value_bits[30:23];
	assign frac = value_bits[22:0];

	always_comb begin
		item.neg   = value_bits[31];
		item.mant  = (bexp == 8'd0) ? {1'b0, frac} : {1'b1, frac};
		item.bexp2 = (bexp == 8'd0) ? -9'sd149 : $signed({1'b0, bexp}) - 9'sd150;
		if (bexp == 8'hFF) begin
			item.kind = KIND_INVALID;
		end else if (bexp == 8'd0 && frac == 23'd0) begin
			item.kind = KIND_ZERO;
			item.neg  = 1'b0;
		end else begin
			item.kind = KIND_NUM;
		end
	end

endmodule

FILE: rtl/fte_fifo.sv
// ----------------------------------------------------------------------------
// fte_fifo
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module fte_fifo import fte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t       entry_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_item;
	end

endmodule

FILE: rtl/fte_back.sv
// ----------------------------------------------------------------------------
// fte_back
// Normalizes the exact ratio by tens, extracts digits by repeated
// subtraction and formats the text field.
// ----------------------------------------------------------------------------
module fte_back import fte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        strobe,
	output logic [7:0]  char_sign,
	output logic [7:0]  char_pos1,
	output logic [7:0]  char_pos2,
	output logic [7:0]  char_pos3,
	output logic [7:0]  char_pos4,
	output logic [7:0]  char_pos5,
	output logic [7:0]  char_exp_sign,
	output logic [7:0]  char_exp_tens,
	output logic [7:0]  char_exp_ones,
	output logic        invalid
);

	state_t            state_q, state_d;
	item_t             item_q;
	wide_t             num_q, den_q;
	wide_t             den10;
	logic signed [7:0] dec_q;
	logic [1:0]        rem_q;
	logic [3:0]        dcount_q;
	logic [DIG_IDX_W-1:0] didx_q;
	logic [3:0]        digit_q [MANT_DIGITS];

	logic [7:0]        dch [MANT_DIGITS];
	logic signed [7:0] exp_fin;
	logic [6:0]        mag;
	logic [3:0]        tens;
	logic [3:0]        ones;

	assign den10 = mul10(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		strobe  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (item_q.kind == KIND_NUM) state_d = ST_NORM_UP;
				else                         state_d = ST_DONE;
			end
			ST_NORM_UP: begin
				if (num_q < den10) state_d = ST_NORM_DN;
			end
			ST_NORM_DN: begin
				if (num_q >= den_q) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (num_q < den_q && didx_q == DIG_IDX_W'(MANT_DIGITS - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				strobe  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (head_valid) item_q <= head_item;
			end
			ST_LOAD: begin
				dec_q    <= 8'sd0;
				rem_q    <= 2'd0;
				dcount_q <= 4'd0;
				didx_q   <= '0;
				for (int i = 0; i < MANT_DIGITS; i++) digit_q[i] <= 4'd0;
				if (item_q.bexp2 >= 0) begin
					num_q <= WIDE_W'(item_q.mant) << item_q.bexp2[7:0];
					den_q <= WIDE_W'(1);
				end else begin
					num_q <= WIDE_W'(item_q.mant);
					den_q <= WIDE_W'(1) << (8'(-item_q.bexp2));
				end
			end
			ST_NORM_UP: begin
				if (num_q >= den10) begin
					den_q <= den10;
					dec_q <= dec_q + 8'sd1;
					rem_q <= (rem_q == 2'd2) ? 2'd0 : rem_q + 2'd1;
				end
			end
			ST_NORM_DN: begin
				if (num_q < den_q) begin
					num_q <= mul10(num_q);
					dec_q <= dec_q - 8'sd1;
					rem_q <= (rem_q == 2'd0) ? 2'd2 : rem_q - 2'd1;
				end
			end
			ST_DIGIT: begin
				if (num_q >= den_q) begin
					num_q    <= num_q - den_q;
					dcount_q <= dcount_q + 4'd1;
				end else begin
					digit_q[didx_q] <= dcount_q;
					num_q           <= mul10(num_q);
					dcount_q        <= 4'd0;
					didx_q          <= didx_q + DIG_IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < MANT_DIGITS; i++) dch[i] = ASCII_ZERO + {4'd0, digit_q[i]};
		exp_fin = dec_q - $signed({6'd0, rem_q});
		mag     = (exp_fin < 0) ? 7'(-exp_fin) : 7'(exp_fin);
		if (mag > 7'd99) mag = 7'd99;
		tens = 4'd0;
		ones = 4'(mag);
		for (int i = 0; i < 9; i++) begin
			if ({3'd0, ones} >= 7'd10 || mag >= 7'(10 * (i + 1))) begin
				if (mag >= 7'(10 * (i + 1))) tens = 4'(i + 1);
			end
		end
		ones = 4'(mag - 7'(tens) * 7'd10);

		invalid       = (item_q.kind == KIND_INVALID);
		char_sign     = item_q.neg ? ASCII_MINUS : ASCII_SPACE;
		char_pos1     = dch[0];
		char_pos2     = (rem_q == 2'd0) ? ASCII_DOT : dch[1];
		char_pos3     = (rem_q == 2'd0) ? dch[1] : (rem_q == 2'd1) ? ASCII_DOT : dch[2];
		char_pos4     = (rem_q == 2'd2) ? ASCII_DOT : dch[2];
		char_pos5     = dch[3];
		char_exp_sign = (exp_fin < 0) ? ASCII_MINUS : ASCII_SPACE;
		char_exp_tens = ASCII_ZERO + {4'd0, tens};
		char_exp_ones = ASCII_ZERO + {4'd0, ones};
		if (invalid) begin
			char_sign     = 8'd0;
			char_pos1     = 8'd0;
			char_pos2     = 8'd0;
			char_pos3     = 8'd0;
			char_pos4     = 8'd0;
			char_pos5     = 8'd0;
			char_exp_sign = 8'd0;
			char_exp_tens = 8'd0;
			char_exp_ones = 8'd0;
		end
	end

endmodule

FILE: rtl/float_to_engineering_text_top.sv
// Sequence: zero, infinity and NaN go from the queue through load straight to done;
// other values pass through normalization by decades and then four digit extractions.
// Throughput: one word per conversion; the 160-bit compare-subtract loop sets it.
// A two-entry queue takes new words while a conversion runs; busy means it is full.
// Reset clears the queue and the sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// float_to_engineering_text_top
// Single-precision value to nine-character engineering-notation text.
// ----------------------------------------------------------------------------
`include "float_to_engineering_text_top_macros.svh"

module float_to_engineering_text_top import fte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value_bits,
	output logic        strobe,
	output logic [7:0]  char_sign,
	output logic [7:0]  char_pos1,
	output logic [7:0]  char_pos2,
	output logic [7:0]  char_pos3,
	output logic [7:0]  char_pos4,
	output logic [7:0]  char_pos5,
	output logic [7:0]  char_exp_sign,
	output logic [7:0]  char_exp_tens,
	output logic [7:0]  char_exp_ones,
	output logic        invalid
);

	item_t front_item, head_item;
	logic  full, head_valid, pop;

	assign busy = full;

	fte_front u_front (
		.value_bits (value_bits),
		.item       (front_item)
	);

	fte_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start && !full),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	fte_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.strobe        (strobe),
		.char_sign     (char_sign),
		.char_pos1     (char_pos1),
		.char_pos2     (char_pos2),
		.char_pos3     (char_pos3),
		.char_pos4     (char_pos4),
		.char_pos5     (char_pos5),
		.char_exp_sign (char_exp_sign),
		.char_exp_tens (char_exp_tens),
		.char_exp_ones (char_exp_ones),
		.invalid       (invalid)
	);

	`FTE_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "strobe held for two cycles")
	`FTE_ASSERT_NOW(a_invalid_blank, strobe && invalid, char_pos1 == 8'd0, "invalid word not blank")
	`FTE_ASSERT_NOW(a_lead_digit, strobe && !invalid, char_pos1 >= ASCII_ZERO && char_pos1 <= 8'h39, "bad lead")
	`FTE_ASSERT_NOW(a_point, strobe && !invalid, char_pos2 == ASCII_DOT || char_pos3 == ASCII_DOT || char_pos4 == ASCII_DOT, "no point")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the float to engineering text converter. A directed table of
// edge values (zeros, infinities, NaNs, subnormals, powers of ten) is walked
// first. A long random run of single-precision patterns follows. Every result
// word is checked, character by character, against its typed table text or a
// bit-exact integer model of the normalization and digit truncation.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fte_pkg::*;

	localparam int RANDOM_WORDS = 1830;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 150;

	typedef logic [191:0] big_t;

	typedef struct packed {
		logic [8:0][7:0] txt;
		logic            inv;
	} eng_text_t;

	typedef struct {
		logic [31:0] bits;
		bit          typed;
		logic [71:0] txt;
		bit          inv;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value_bits;
	logic        strobe;
	logic [7:0]  char_sign, char_pos1, char_pos2, char_pos3, char_pos4, char_pos5;
	logic [7:0]  char_exp_sign, char_exp_tens, char_exp_ones;
	logic        invalid;

	eng_text_t pending_text[$];
	int        mismatches;
	int        words_in, words_out, invalid_seen, subnormal_sent;
	longint    cycles;

	float_to_engineering_text_top dut (
		.clk, .arst_n, .start, .busy, .value_bits, .strobe,
		.char_sign, .char_pos1, .char_pos2, .char_pos3, .char_pos4, .char_pos5,
		.char_exp_sign, .char_exp_tens, .char_exp_ones, .invalid
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	function automatic eng_text_t format_value(input logic [31:0] bits);
		eng_text_t   r;
		logic [7:0]  exp8;
		logic [23:0] mant;
		int          e2, dec, lead, pos, d, mag;
		big_t        num, den, tmp;
		logic [7:0]  chars[5];
		r = '0;
		exp8 = bits[30:23];
		if (exp8 == 8'hFF) begin
			r.inv = 1'b1;
			return r;
		end
		mant = (exp8 == 0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
		e2 = (exp8 == 0) ? -149 : int'(exp8) - 150;
		dec = 0;
		pos = 0;
		if (mant == 0) begin
			r.txt = {" 0.000 00"};
			return r;
		end
		if (e2 >= 0) begin
			num = big_t'(mant) << e2;
			den = 1;
		end else begin
			num = big_t'(mant);
			den = big_t'(1) << (-e2);
		end
		forever begin
			tmp = den * 10;
			if (num < tmp) break;
			den = tmp;
			dec++;
		end
		while (num < den) begin
			num = num * 10;
			dec--;
		end
		lead = 1 + (((dec % 3) + 3) % 3);
		for (int k = 0; k < MANT_DIGITS; k++) begin
			d = 0;
			while (d < 9 && num >= den) begin
				num = num - den;
				d++;
			end
			if (pos < 5) chars[pos] = ASCII_ZERO + 8'(d);
			pos++;
			if (k + 1 == lead) begin
				if (pos < 5) chars[pos] = ASCII_DOT;
				pos++;
			end
			num = num * 10;
		end
		dec -= lead - 1;
		mag = dec < 0 ? -dec : dec;
		if (mag > 99) mag = 99;
		r.txt = {bits[31] ? ASCII_MINUS : ASCII_SPACE,
			chars[0], chars[1], chars[2], chars[3], chars[4],
			dec < 0 ? ASCII_MINUS : ASCII_SPACE,
			ASCII_ZERO + 8'(mag / 10), ASCII_ZERO + 8'(mag % 10)};
		return r;
	endfunction

	task automatic send_word(input logic [31:0] bits, input bit typed, input eng_text_t typed_text);
		start <= 1'b1;
		value_bits <= bits;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_text.push_back(typed ? typed_text : format_value(bits));
		words_in++;
		if (bits[30:23] == 8'h00 && bits[22:0] != 0) subnormal_sent++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'h00;
			1: v[30:23] = 8'hFF;
			2: v[30:0] = 31'h0;
			3: v[30:23] = 8'($urandom_range(110, 145));
			4: v[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'h01;
			5: v[22:0] = $urandom_range(0, 1) ? 23'h0 : 23'h7FFFFF;
			default: ;
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		eng_text_t exp_t;
		logic [71:0] got;
		string names[9];
		names = '{"char_sign", "char_pos1", "char_pos2", "char_pos3", "char_pos4",
			"char_pos5", "char_exp_sign", "char_exp_tens", "char_exp_ones"};
		if (arst_n && strobe) begin
			got = {char_sign, char_pos1, char_pos2, char_pos3, char_pos4, char_pos5,
				char_exp_sign, char_exp_tens, char_exp_ones};
			words_out++;
			if (invalid) invalid_seen++;
			if (pending_text.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: result word with none expected");
			end else begin
				exp_t = pending_text.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[71 - 8*k -: 8] !== exp_t.txt[8 - k]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: word %0d %s expected %h got %h", words_out,
								names[k], exp_t.txt[8 - k], got[71 - 8*k -: 8]);
					end
				if (invalid !== exp_t.inv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d invalid expected %b got %b", words_out,
							exp_t.inv, invalid);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		vector_t   table_rows[$];
		eng_text_t tt;
		int        burst;
		bit        drained;
		start = 1'b0;
		value_bits = '0;
		arst_n = 1'b0;
		mismatches = 0;
		words_in = 0;
		words_out = 0;
		invalid_seen = 0;
		subnormal_sent = 0;
		cycles = 0;
		drained = 1'b0;
		table_rows = '{
			'{32'h0000_0000, 1, {" 0.000 00"}, 0},
			'{32'h8000_0000, 1, {" 0.000 00"}, 0},
			'{32'h7F80_0000, 1, 72'h0, 1},
			'{32'hFF80_0000, 1, 72'h0, 1},
			'{32'h7FC0_0000, 1, 72'h0, 1},
			'{32'hFFFF_FFFF, 1, 72'h0, 1},
			'{32'h7F80_0001, 1, 72'h0, 1},
			'{32'h3F80_0000, 1, {" 1.000 00"}, 0},
			'{32'hBF80_0000, 1, {"-1.000 00"}, 0},
			'{32'h4120_0000, 1, {" 10.00 00"}, 0},
			'{32'h42C8_0000, 1, {" 100.0 00"}, 0},
			'{32'h447A_0000, 1, {" 1.000 03"}, 0},
			'{32'h0000_0001, 0, 72'h0, 0},
			'{32'h8000_0001, 0, 72'h0, 0},
			'{32'h007F_FFFF, 0, 72'h0, 0},
			'{32'h0080_0000, 0, 72'h0, 0},
			'{32'h7F7F_FFFF, 0, 72'h0, 0},
			'{32'hFF7F_FFFF, 0, 72'h0, 0},
			'{32'h3DCC_CCCD, 0, 72'h0, 0},
			'{32'h3C23_D70A, 0, 72'h0, 0},
			'{32'h3A83_126F, 0, 72'h0, 0},
			'{32'h4049_0FDB, 0, 72'h0, 0},
			'{32'h5368_D4A5, 0, 72'h0, 0},
			'{32'h2EDB_E6FF, 0, 72'h0, 0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) begin
			tt.txt = table_rows[i].txt;
			tt.inv = table_rows[i].inv;
			send_word(table_rows[i].bits, table_rows[i].typed, tt);
		end
		idle_cycles(1);
		for (int n = 0; n < RANDOM_WORDS; ) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && n < RANDOM_WORDS; b++, n++)
				send_word(random_value(), 0, '0);
			if (!drained && n >= RANDOM_WORDS / 2) begin
				drained = 1'b1;
				start <= 1'b0;
				while (pending_text.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				idle_cycles($urandom_range(1, 40));
			end
		end
		start <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d words, %0d checked; %0d flagged invalid, %0d subnormal inputs.",
			words_in, words_out, invalid_seen, subnormal_sent);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0 && pending_text.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
